// ===== rtl/lps_pkg.sv =====
// Shared constants, codes and types of the LED pixel serializer.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  // Store geometry
  localparam int GRID_SIDE = 5;
  localparam int PIXELS    = 25;

  // Field widths
  localparam int COORD_W = 3;
  localparam int COLOR_W = 8;
  localparam int WORD_W  = 3 * COLOR_W;
  localparam int FUNC_W  = 3;
  localparam int SHORT_W = 8;
  localparam int RST_W   = 12;
  localparam int PCNT_W  = 5;
  localparam int BIT_W   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;

  // Derived widths
  localparam int IDX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CNT_W  = ($clog2(PIXELS + 1) > PCNT_W) ? $clog2(PIXELS + 1) : PCNT_W;
  localparam int SIDE_W = ($clog2(GRID_SIDE + 1) > COORD_W) ? $clog2(GRID_SIDE + 1) : COORD_W;
  localparam int LIN_W  = $clog2(GRID_SIDE * GRID_SIDE + 1);

  // Item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 3'd0,
    FUNC_PIXEL = 3'd1,
    FUNC_ROW   = 3'd2,
    FUNC_COL   = 3'd3,
    FUNC_ALL   = 3'd4,
    FUNC_START = 3'd5
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH = 3'd0,
    CFG_ZERO_LOW  = 3'd1,
    CFG_ONE_HIGH  = 3'd2,
    CFG_ONE_LOW   = 3'd3,
    CFG_RESET     = 3'd4,
    CFG_PCOUNT    = 3'd5
  } cfg_reg_e;

  // Serializer phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_LEAD  = 5'b00010,
    PH_HIGH  = 5'b00100,
    PH_LOW   = 5'b01000,
    PH_TRAIL = 5'b10000
  } phase_e;

  // Store operations
  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_ROW   = 2'd1,
    OP_COL   = 2'd2,
    OP_ALL   = 2'd3
  } store_op_e;

  typedef struct packed {
    logic               valid;
    store_op_e          op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } store_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lps_store.sv =====
// Pixel store: synchronous memory with valid flags and a row/column fill sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lps_store
  import lps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire store_cmd_t        cmd_i,
  input  wire logic [WORD_W-1:0] word_i,
  input  wire logic [IDX_W-1:0]  rd_addr_i,
  output logic [WORD_W-1:0]      rd_word_o,
  output logic                   busy_o
);

  logic [WORD_W-1:0] mem [PIXELS];
  logic [PIXELS-1:0] valid_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              rd_valid_q;

  logic              fill_q, fill_d;
  store_op_e         mode_q, mode_d;
  logic [SIDE_W-1:0] col_q, col_d, row_q, row_d;
  logic [WORD_W-1:0] word_q, word_d;

  logic [SIDE_W-1:0] wr_col, wr_row;
  logic [WORD_W-1:0] wr_word;
  logic              wr_try;
  logic [LIN_W-1:0]  wr_lin;
  logic              wr_en;
  logic [SIDE_W-1:0] x_ext, y_ext;
  logic              last_col, last_row;

  assign x_ext    = SIDE_W'(cmd_i.x);
  assign y_ext    = SIDE_W'(cmd_i.y);
  assign last_col = (col_q == SIDE_W'(GRID_SIDE - 1));
  assign last_row = (row_q == SIDE_W'(GRID_SIDE - 1));

  always_comb begin
    fill_d  = fill_q;
    mode_d  = mode_q;
    col_d   = col_q;
    row_d   = row_q;
    word_d  = word_q;
    wr_try  = 1'b0;
    wr_col  = col_q;
    wr_row  = row_q;
    wr_word = word_q;
    if (fill_q) begin
      // Write one entry per cycle, advance along the row, the column or the grid
      wr_try = 1'b1;
      case (mode_q)
        OP_ROW: begin
          col_d = col_q + 1'b1;
          if (last_col) fill_d = 1'b0;
        end
        OP_COL: begin
          row_d = row_q + 1'b1;
          if (last_row) fill_d = 1'b0;
        end
        default: begin
          if (last_col) begin
            col_d = '0;
            row_d = row_q + 1'b1;
            if (last_row) fill_d = 1'b0;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      endcase
    end else if (cmd_i.valid) begin
      word_d = word_i;
      mode_d = cmd_i.op;
      unique case (cmd_i.op)
        OP_PIXEL: begin
          wr_try  = (x_ext < SIDE_W'(GRID_SIDE)) && (y_ext < SIDE_W'(GRID_SIDE));
          wr_col  = x_ext;
          wr_row  = y_ext;
          wr_word = word_i;
        end
        OP_ROW: begin
          fill_d = (y_ext < SIDE_W'(GRID_SIDE));
          col_d  = '0;
          row_d  = y_ext;
        end
        OP_COL: begin
          fill_d = (x_ext < SIDE_W'(GRID_SIDE));
          col_d  = x_ext;
          row_d  = '0;
        end
        OP_ALL: begin
          fill_d = 1'b1;
          col_d  = '0;
          row_d  = '0;
        end
        default: ;
      endcase
    end
    wr_lin = LIN_W'(wr_col) + LIN_W'(GRID_SIDE) * LIN_W'(wr_row);
    wr_en  = wr_try && (wr_lin < LIN_W'(PIXELS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (wr_en) valid_q[IDX_W'(wr_lin)] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    col_q  <= col_d;
    row_q  <= row_d;
    word_q <= word_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[IDX_W'(wr_lin)] <= wr_word;
    rd_data_q  <= mem[rd_addr_i];
    rd_valid_q <= valid_q[rd_addr_i];
  end

  // An entry never written reads as zero
  assign rd_word_o = rd_valid_q ? rd_data_q : '0;
  assign busy_o    = fill_q;

endmodule

`default_nettype wire

// ===== rtl/led_pixel_serializer_unit.sv =====
// Top level of the LED pixel serializer: item decode, bit timing sequencer, result register.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   func_i x_i y_i green_i red_i blue_i
//   out      output     out_valid_o / out_ready_i pin_level_o busy_res_o frame_done_o rejected_o
//   cfg      input      cfg_we_i                  cfg_idx_i cfg_wdata_i
//
// Tick, pixel write and start items do not keep the input closed. A row or column fill
// keeps the input closed after its item until every entry of its line is written, a full
// fill until the whole grid is written: the store has a single write port, one entry per cycle.
// Reset clears control state; store entries read as zero through per-entry valid
// flags until written, so no clearing pass runs.
// The result register holds one item; a new item enters as long as the store is not
// filling and that register is empty or is being drained in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module led_pixel_serializer_unit
  import lps_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // item input
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [FUNC_W-1:0]    func_i,
  input  wire logic [COORD_W-1:0]   x_i,
  input  wire logic [COORD_W-1:0]   y_i,
  input  wire logic [COLOR_W-1:0]   green_i,
  input  wire logic [COLOR_W-1:0]   red_i,
  input  wire logic [COLOR_W-1:0]   blue_i,
  // result output
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      pin_level_o,
  output logic                      busy_res_o,
  output logic                      frame_done_o,
  output logic                      rejected_o,
  // configuration writes
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [SHORT_W-1:0] zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [RST_W-1:0]   reset_ticks_q;
  logic [PCNT_W-1:0]  pixel_count_q;

  // Sequencer state
  phase_e             phase_q, phase_d;
  logic [RST_W-1:0]   tick_q, tick_d;
  logic [IDX_W-1:0]   pix_q, pix_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [WORD_W-1:0]  shift_q, shift_d;
  logic               pin_q, pin_d;

  // Result register
  logic out_valid_q;
  logic level_q, level_d, busy_q, busy_d, done_q, done_d, rej_q, rej_d;

  // Store interface
  store_cmd_t         cmd;
  logic [WORD_W-1:0]  rd_word;
  logic [IDX_W-1:0]   rd_addr;
  logic               store_busy;

  logic               accept, busy;
  logic [RST_W-1:0]   tick_inc, part_len;
  logic [CNT_W-1:0]   frame_pix, pcount_ext, nxt_pix;
  logic [BIT_W-1:0]   bit_inc;

  assign in_ready_o = !store_busy && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign busy       = (phase_q != PH_IDLE);

  assign pcount_ext = CNT_W'(pixel_count_q);
  assign frame_pix  = (pcount_ext > CNT_W'(PIXELS)) ? CNT_W'(PIXELS) : pcount_ext;
  assign nxt_pix    = CNT_W'(pix_q) + 1'b1;
  assign tick_inc   = tick_q + 1'b1;
  assign bit_inc    = bit_q + 1'b1;

  // Prefetch: during the leading reset (and idle) read pixel zero, during a pixel
  // read the one after it, so the word is ready when the next load happens
  always_comb begin
    rd_addr = '0;
    if (((phase_q == PH_HIGH) || (phase_q == PH_LOW)) && (nxt_pix < CNT_W'(PIXELS))) begin
      rd_addr = IDX_W'(nxt_pix);
    end
  end

  // Length of the current part of the waveform
  always_comb begin
    unique case (phase_q)
      PH_HIGH: part_len = RST_W'(shift_q[WORD_W-1] ? one_high_q : zero_high_q);
      PH_LOW:  part_len = RST_W'(shift_q[WORD_W-1] ? one_low_q : zero_low_q);
      default: part_len = reset_ticks_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    pix_d   = pix_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pin_d   = pin_q;
    level_d = ~pin_q;
    busy_d  = busy;
    done_d  = 1'b0;
    rej_d   = 1'b0;
    cmd       = '0;
    cmd.op    = OP_PIXEL;
    cmd.x     = x_i;
    cmd.y     = y_i;

    if (accept) begin
      unique case (func_i)
        FUNC_TICK: begin
          if (busy) begin
            if (tick_inc < part_len) begin
              tick_d = tick_inc;
            end else begin
              // Part ends: move to the next one
              tick_d = '0;
              unique case (phase_q)
                PH_LEAD: begin
                  pix_d = '0;
                  if (frame_pix == '0) begin
                    phase_d = PH_TRAIL;
                  end else begin
                    shift_d = rd_word;
                    bit_d   = '0;
                    phase_d = PH_HIGH;
                  end
                end
                PH_HIGH: phase_d = PH_LOW;
                PH_LOW: begin
                  shift_d = {shift_q[WORD_W-2:0], 1'b0};
                  bit_d   = bit_inc;
                  if (bit_inc >= BIT_W'(WORD_W)) begin
                    pix_d = IDX_W'(nxt_pix);
                    if (nxt_pix >= frame_pix) begin
                      phase_d = PH_TRAIL;
                      bit_d   = '0;
                    end else begin
                      shift_d = rd_word;
                      bit_d   = '0;
                      phase_d = PH_HIGH;
                    end
                  end else begin
                    phase_d = PH_HIGH;
                  end
                end
                PH_TRAIL: begin
                  phase_d = PH_IDLE;
                  pix_d   = '0;
                  done_d  = 1'b1;
                end
                default: phase_d = PH_IDLE;
              endcase
              pin_d = (phase_d == PH_HIGH);
            end
          end
        end
        FUNC_PIXEL, FUNC_ROW, FUNC_COL, FUNC_ALL: begin
          if (busy) begin
            rej_d = 1'b1;
          end else begin
            cmd.valid = 1'b1;
            unique case (func_i)
              FUNC_ROW: cmd.op = OP_ROW;
              FUNC_COL: cmd.op = OP_COL;
              FUNC_ALL: cmd.op = OP_ALL;
              default:  cmd.op = OP_PIXEL;
            endcase
          end
        end
        FUNC_START: begin
          if (busy) begin
            rej_d = 1'b1;
          end else begin
            phase_d = PH_LEAD;
            tick_d  = '0;
            pix_d   = '0;
            bit_d   = '0;
            shift_d = '0;
            pin_d   = 1'b0;
            busy_d  = 1'b1;
            level_d = 1'b1;
          end
        end
        default: ; // unused codes: report status, change nothing
      endcase
    end
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q   <= SHORT_W'(17);
      zero_low_q    <= SHORT_W'(38);
      one_high_q    <= SHORT_W'(34);
      one_low_q     <= SHORT_W'(29);
      reset_ticks_q <= RST_W'(2400);
      pixel_count_q <= PCNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ZERO_HIGH: zero_high_q   <= cfg_wdata_i[SHORT_W-1:0];
        CFG_ZERO_LOW:  zero_low_q    <= cfg_wdata_i[SHORT_W-1:0];
        CFG_ONE_HIGH:  one_high_q    <= cfg_wdata_i[SHORT_W-1:0];
        CFG_ONE_LOW:   one_low_q     <= cfg_wdata_i[SHORT_W-1:0];
        CFG_RESET:     reset_ticks_q <= cfg_wdata_i[RST_W-1:0];
        CFG_PCOUNT:    pixel_count_q <= cfg_wdata_i[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      pix_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      pin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      pix_q   <= pix_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pin_q   <= pin_d;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q <= level_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      rej_q   <= rej_d;
    end
  end

  lps_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .word_i    ({green_i, red_i, blue_i}),
    .rd_addr_i (rd_addr),
    .rd_word_o (rd_word),
    .busy_o    (store_busy)
  );

  assign out_valid_o  = out_valid_q;
  assign pin_level_o  = level_q;
  assign busy_res_o   = busy_q;
  assign frame_done_o = done_q;
  assign rejected_o   = rej_q;

endmodule

`default_nettype wire

// ===== bench/led_pixel_serializer_unit_tb.sv =====
// Self-checking testbench for the LED pixel serializer: store writes, fills and refresh timing.
`timescale 1ns / 1ps

module led_pixel_serializer_unit_tb;
  import lps_pkg::*;

  // Spare function codes: the block must ignore them without touching time
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

  // Generous cap on the whole run; a correct run needs a small fraction of it
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } status_t;

  // DUT signals; every driven input is known from time zero
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [FUNC_W-1:0]    func_i      = '0;
  logic [COORD_W-1:0]   x_i         = '0;
  logic [COORD_W-1:0]   y_i         = '0;
  logic [COLOR_W-1:0]   green_i     = '0;
  logic [COLOR_W-1:0]   red_i       = '0;
  logic [COLOR_W-1:0]   blue_i      = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 pin_level_o;
  logic                 busy_res_o;
  logic                 frame_done_o;
  logic                 rejected_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  // Predictor state: pixel store, frame sequencer and live register copies
  logic [WORD_W-1:0] led_store [PIXELS];
  phase_e            seq_phase   = PH_IDLE;
  logic [RST_W-1:0]  tick_cnt    = '0;
  logic [4:0]        cur_pixel   = '0;
  logic [BIT_W-1:0]  cur_bit     = '0;
  logic [WORD_W-1:0] out_word    = '0;
  logic              line_active = 1'b0;
  logic [SHORT_W-1:0] t0h = 8'd17, t0l = 8'd38, t1h = 8'd34, t1l = 8'd29;
  logic [RST_W-1:0]   reset_len     = 12'd2400;
  logic [PCNT_W-1:0]  frame_len_cfg = 5'd1;

  // Expected status of every accepted item, oldest first
  status_t status_q [$];

  int send_idle_pct = 17;
  int recv_idle_pct = 75;
  int items_sent    = 0;
  int mismatches    = 0;
  int cycle_cnt     = 0;

  led_pixel_serializer_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .func_i, .x_i, .y_i, .green_i, .red_i, .blue_i,
    .out_valid_o, .out_ready_i, .pin_level_o, .busy_res_o, .frame_done_o, .rejected_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Drop writes outside the grid, as the block does
  function automatic void store_put(int col, int row, logic [WORD_W-1:0] rgb);
    if (col >= GRID_SIDE || row >= GRID_SIDE) return;
    if (col + GRID_SIDE * row >= PIXELS) return;
    led_store[col + GRID_SIDE * row] = rgb;
  endfunction

  // Clamp the pixel count register to the store size
  function automatic int frame_pixel_total();
    return (frame_len_cfg > PIXELS) ? PIXELS : int'(frame_len_cfg);
  endfunction

  function automatic void begin_pixel();
    out_word  = (cur_pixel < PIXELS) ? led_store[cur_pixel] : '0;
    cur_bit   = '0;
    seq_phase = PH_HIGH;
  endfunction

  // Work out the status of one item and advance the predictor by it
  function automatic status_t predict_item(logic [FUNC_W-1:0] fn, logic [COORD_W-1:0] col,
                                           logic [COORD_W-1:0] row, logic [WORD_W-1:0] rgb);
    status_t          res;
    logic [RST_W-1:0] seg_len;
    logic             in_frame;
    in_frame       = (seq_phase != PH_IDLE);
    res.pin_level  = ~line_active;
    res.busy_res   = in_frame;
    res.frame_done = 1'b0;
    res.rejected   = 1'b0;
    if (fn == FUNC_TICK) begin
      if (in_frame) begin
        tick_cnt = tick_cnt + 1'b1;
        // Lengths are read live; the top bit of the word picks the bit type
        case (seq_phase)
          PH_HIGH: seg_len = out_word[WORD_W-1] ? RST_W'(t1h) : RST_W'(t0h);
          PH_LOW:  seg_len = out_word[WORD_W-1] ? RST_W'(t1l) : RST_W'(t0l);
          default: seg_len = reset_len;
        endcase
        // A zero length ends the part after one tick, like a length of one
        if (tick_cnt >= seg_len) begin
          tick_cnt = '0;
          case (seq_phase)
            PH_LEAD: begin
              cur_pixel = '0;
              if (frame_pixel_total() == 0) seq_phase = PH_TRAIL;
              else begin_pixel();
            end
            PH_HIGH: seq_phase = PH_LOW;
            PH_LOW: begin
              out_word = out_word << 1;
              cur_bit  = cur_bit + 1'b1;
              if (cur_bit >= WORD_W) begin
                cur_pixel = cur_pixel + 1'b1;
                if (cur_pixel >= frame_pixel_total()) begin
                  seq_phase = PH_TRAIL;
                  cur_bit   = '0;
                end else begin
                  begin_pixel();
                end
              end else begin
                seq_phase = PH_HIGH;
              end
            end
            PH_TRAIL: begin
              seq_phase      = PH_IDLE;
              cur_pixel      = '0;
              res.frame_done = 1'b1;
            end
            default: seq_phase = PH_IDLE;
          endcase
          line_active = (seq_phase == PH_HIGH);
        end
      end
    end else if (fn <= FUNC_START) begin
      if (in_frame) begin
        res.rejected = 1'b1;
      end else begin
        case (fn)
          FUNC_PIXEL: store_put(col, row, rgb);
          FUNC_ROW:   for (int i = 0; i < GRID_SIDE; i++) store_put(i, row, rgb);
          FUNC_COL:   for (int i = 0; i < GRID_SIDE; i++) store_put(col, i, rgb);
          FUNC_ALL: begin
            for (int j = 0; j < GRID_SIDE; j++)
              for (int i = 0; i < GRID_SIDE; i++) store_put(i, j, rgb);
          end
          default: begin
            // Start: the first tick after it is the first tick of the leading reset
            seq_phase     = PH_LEAD;
            tick_cnt      = '0;
            cur_pixel     = '0;
            cur_bit       = '0;
            out_word      = '0;
            line_active   = 1'b0;
            res.busy_res  = 1'b1;
            res.pin_level = 1'b1;
          end
        endcase
      end
    end
    // Spare codes fall through: no change, current status, not rejected
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Offer one item at a falling edge, hold it until accepted, record its status
  task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [WORD_W-1:0] rgb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    x_i        <= col;
    y_i        <= row;
    green_i    <= rgb[23:16];
    red_i      <= rgb[15:8];
    blue_i     <= rgb[7:0];
    do @(posedge clk_i); while (!in_ready_o);
    status_q.push_back(predict_item(fn, col, row, rgb));
    items_sent++;
    @(negedge clk_i);
  endtask

  // Ticks carry random coordinates and colors; the block must ignore them
  task automatic send_tick();
    send_item(FUNC_TICK, 3'($urandom), 3'($urandom), 24'($urandom));
  endtask

  // Write a register once the block has returned every outstanding result
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DAT_W-1:0] val);
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    case (idx)
      CFG_ZERO_HIGH: t0h = val[SHORT_W-1:0];
      CFG_ZERO_LOW:  t0l = val[SHORT_W-1:0];
      CFG_ONE_HIGH:  t1h = val[SHORT_W-1:0];
      CFG_ONE_LOW:   t1l = val[SHORT_W-1:0];
      CFG_RESET:     reset_len = val[RST_W-1:0];
      CFG_PCOUNT:    frame_len_cfg = val[PCNT_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Set all four bit lengths at once
  task automatic write_bit_lengths(logic [CFG_DAT_W-1:0] val);
    write_reg(CFG_ZERO_HIGH, val);
    write_reg(CFG_ZERO_LOW, val);
    write_reg(CFG_ONE_HIGH, val);
    write_reg(CFG_ONE_LOW, val);
  endtask

  // Keep random frames short: small lengths and counts, junk in the unused upper bits
  task automatic write_random_reg(cfg_reg_e idx);
    logic [CFG_DAT_W-1:0] val;
    case (idx)
      CFG_RESET:  val = CFG_DAT_W'($urandom_range(0, 6));
      CFG_PCOUNT: val = {7'($urandom), 5'($urandom_range(0, 2))};
      default:    val = {4'($urandom), 8'($urandom_range(0, 2))};
    endcase
    write_reg(idx, val);
  endtask

  task automatic send_random_request();
    int                 roll;
    logic [FUNC_W-1:0]  fn;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    roll = $urandom_range(0, 99);
    if (roll < 45)      fn = FUNC_PIXEL;
    else if (roll < 60) fn = FUNC_ROW;
    else if (roll < 75) fn = FUNC_COL;
    else if (roll < 80) fn = FUNC_ALL;
    else if (roll < 87) fn = FUNC_TICK;
    else if (roll < 92) fn = FUNC_START;
    else                fn = FUNC_W'($urandom_range(6, 7));
    // Mostly on the grid, sometimes off it
    col = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom);
    row = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom);
    send_item(fn, col, row, 24'($urandom));
  endtask

  // Tick until the sequencer reaches the given phase, with optional stray requests
  task automatic tick_until(phase_e target, bit noisy);
    while (seq_phase != target) begin
      if (noisy && $urandom_range(0, 99) < 5) send_random_request();
      else send_tick();
    end
  endtask

  task automatic run_frame(bit noisy);
    send_item(FUNC_START, 3'($urandom), 3'($urandom), 24'($urandom));
    tick_until(PH_IDLE, noisy);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values of the registers: idle ticks, spare codes, the default zero-bit
  // active length, and every request type rejected while busy
  task automatic test_power_up_defaults();
    send_tick();
    send_item(FUNC_SPARE_A, 3'd7, 3'd7, 24'hFFFFFF);
    send_item(FUNC_SPARE_B, 3'd0, 3'd0, 24'h000000);
    send_item(FUNC_START, 3'd0, 3'd0, 24'h0);
    send_tick();
    send_item(FUNC_PIXEL, 3'd0, 3'd0, 24'hFFFFFF);
    send_item(FUNC_ROW, 3'd1, 3'd1, 24'hFFFFFF);
    send_item(FUNC_COL, 3'd1, 3'd1, 24'hFFFFFF);
    send_item(FUNC_ALL, 3'd0, 3'd0, 24'hFFFFFF);
    send_item(FUNC_START, 3'd0, 3'd0, 24'h0);
    send_item(FUNC_SPARE_A, 3'd0, 3'd0, 24'h0);
    repeat (4) send_tick();
    // Cut the leading reset short, keep the default length for one active part
    write_reg(CFG_RESET, 12'd3);
    tick_until(PH_LOW, 1'b0);
    write_bit_lengths(12'd1);
    tick_until(PH_IDLE, 1'b0);
    send_tick();
  endtask

  // Every store operation, color extremes and off-grid coordinates, then read
  // the first two rows back through a frame; a one bit lasts longer than a zero
  task automatic test_store_writes();
    write_reg(CFG_ZERO_HIGH, 12'd1);
    write_reg(CFG_ZERO_LOW, 12'd1);
    write_reg(CFG_ONE_HIGH, 12'd2);
    write_reg(CFG_ONE_LOW, 12'd1);
    write_reg(CFG_RESET, 12'd2);
    write_reg(CFG_PCOUNT, 12'd10);
    send_item(FUNC_ALL, 3'd0, 3'd0, 24'h5A3C96);
    send_item(FUNC_ROW, 3'd0, 3'd1, 24'hFFFFFF);
    send_item(FUNC_COL, 3'd0, 3'd0, 24'h000000);
    send_item(FUNC_PIXEL, 3'd4, 3'd1, 24'hA5C3E1);
    send_item(FUNC_PIXEL, 3'd0, 3'd0, 24'hFFFFFF);
    send_item(FUNC_PIXEL, 3'd2, 3'd0, 24'h010203);
    send_item(FUNC_PIXEL, 3'd5, 3'd0, 24'h123456);
    send_item(FUNC_PIXEL, 3'd0, 3'd5, 24'h123456);
    send_item(FUNC_PIXEL, 3'd7, 3'd7, 24'h123456);
    send_item(FUNC_ROW, 3'd0, 3'd5, 24'h654321);
    send_item(FUNC_ROW, 3'd0, 3'd7, 24'h654321);
    send_item(FUNC_COL, 3'd6, 3'd0, 24'h654321);
    send_item(FUNC_COL, 3'd7, 3'd0, 24'h654321);
    run_frame(1'b0);
  endtask

  // Zero lengths act as one; a count of zero skips the pixels
  task automatic test_count_limits();
    write_bit_lengths(12'd0);
    write_reg(CFG_RESET, 12'd0);
    write_reg(CFG_PCOUNT, 12'd0);
    run_frame(1'b0);
    write_reg(CFG_PCOUNT, 12'd1);
    run_frame(1'b0);
  endtask

  // Change lengths and the pixel count in the middle of a frame
  task automatic test_live_registers();
    write_bit_lengths(12'd1);
    write_reg(CFG_RESET, 12'd20);
    write_reg(CFG_PCOUNT, 12'd1);
    send_item(FUNC_START, 3'd0, 3'd0, 24'h0);
    repeat (10) send_tick();
    write_reg(CFG_RESET, 12'd5);
    tick_until(PH_HIGH, 1'b0);
    write_reg(CFG_ONE_HIGH, 12'd3);
    write_reg(CFG_ZERO_HIGH, 12'd3);
    write_reg(CFG_PCOUNT, 12'd2);
    tick_until(PH_IDLE, 1'b0);
  endtask

  // Largest length on the first active part, then short bits to end the frame
  task automatic test_long_timing();
    write_bit_lengths(12'd255);
    write_reg(CFG_RESET, 12'd3);
    write_reg(CFG_PCOUNT, 12'd1);
    send_item(FUNC_PIXEL, 3'd0, 3'd0, 24'hAAAAAA);
    send_item(FUNC_START, 3'd0, 3'd0, 24'h0);
    tick_until(PH_LOW, 1'b0);
    write_bit_lengths(12'd1);
    tick_until(PH_IDLE, 1'b0);
  endtask

  // Bursts of random store traffic, each followed by a frame with stray requests,
  // under three idling mixes
  task automatic test_random_traffic();
    int stop_at;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       set_idling(17, 75);
        1:       set_idling(75, 17);
        default: set_idling(0, 0);
      endcase
      for (int r = 0; r < 6; r++) write_random_reg(cfg_reg_e'(r));
      stop_at = items_sent + 150;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 99) < 30) begin
          repeat ($urandom_range(1, 2)) write_random_reg(cfg_reg_e'($urandom_range(0, 5)));
        end
        repeat ($urandom_range(0, 8)) send_random_request();
        run_frame(1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each returned item against the oldest expectation
  always @(posedge clk_i) begin : check_results
    status_t exp_st;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (status_q.size() == 0) begin
        $error("result returned with no item outstanding");
        mismatches++;
      end else begin
        exp_st = status_q.pop_front();
        if (pin_level_o !== exp_st.pin_level) begin
          $error("pin_level: expected %0b, actual %0b", exp_st.pin_level, pin_level_o);
          mismatches++;
        end
        if (busy_res_o !== exp_st.busy_res) begin
          $error("busy_res: expected %0b, actual %0b", exp_st.busy_res, busy_res_o);
          mismatches++;
        end
        if (frame_done_o !== exp_st.frame_done) begin
          $error("frame_done: expected %0b, actual %0b", exp_st.frame_done, frame_done_o);
          mismatches++;
        end
        if (rejected_o !== exp_st.rejected) begin
          $error("rejected: expected %0b, actual %0b", exp_st.rejected, rejected_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    foreach (led_store[i]) led_store[i] = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(17, 75);
    test_power_up_defaults();
    test_store_writes();
    test_count_limits();
    test_live_registers();
    test_long_timing();
    test_random_traffic();

    // Drain: wait for every result, then let any fill still writing finish
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
